/* rtl/core/isre_pkg.sv */
`timescale 1ns / 1ps
package isre_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam logic [15:0] RST_RULE_SET_ID = 16'd256;
    localparam logic [15:0] RST_IPV4_TMPL   = 16'd901;
    localparam logic [15:0] RST_IPV6_TMPL   = 16'd902;
    localparam logic [15:0] PROTO_VERSION   = 16'd10;
    localparam logic [15:0] MSG_HDR_LEN     = 16'd16;
    localparam logic [15:0] TEMPLATE_SET_ID = 16'd2;
    localparam logic [4:0]  E4_LAST         = 5'd8;
    localparam logic [4:0]  E6_LAST         = 5'd20;
    localparam logic [16:0] E4_BYTES        = 17'd9;
    localparam logic [16:0] E6_BYTES        = 17'd21;

    localparam logic [1:0] CFG_RULE_SET_ID = 2'd0;
    localparam logic [1:0] CFG_IPV4_TMPL   = 2'd1;
    localparam logic [1:0] CFG_IPV6_TMPL   = 2'd2;

    typedef enum logic [3:0] {
        PH_MHDR   = 4'd0,
        PH_MSKIP  = 4'd1,
        PH_SHDR   = 4'd2,
        PH_SSKIP  = 4'd3,
        PH_RHDR   = 4'd4,
        PH_POLICY = 4'd5,
        PH_LHDR   = 4'd6,
        PH_LSKIP  = 4'd7,
        PH_E4     = 4'd8,
        PH_E6     = 4'd9
    } t_phase;

    typedef enum logic [2:0] {
        EV_RULE        = 3'd0,
        EV_BAD_VERSION = 3'd1,
        EV_BAD_MSG_LEN = 3'd2,
        EV_BAD_SET_LEN = 3'd3,
        EV_TRUNC_REC   = 3'd4,
        EV_BAD_LIST    = 3'd5
    } t_event;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [31:0] interface_id;
        logic [31:0] ipv4_prefix;
        logic [7:0]  prefix_length;
        logic [7:0]  rule_kind;
        logic [7:0]  target_kind;
        logic [31:0] rules_decoded;
    } t_result;

    typedef struct packed {
        logic [15:0] rule_set_id;
        logic [15:0] ipv4_list_template;
        logic [15:0] ipv6_list_template;
    } t_cfg;

endpackage

/* rtl/core/isre_in_if.sv */
`timescale 1ns / 1ps
interface isre_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_start;
    modport source (output valid, output data_byte, output stream_start, input ready);
    modport sink (input valid, input data_byte, input stream_start, output ready);
endinterface

/* rtl/core/isre_out_if.sv */
`timescale 1ns / 1ps
interface isre_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [31:0] interface_id;
    logic [31:0] ipv4_prefix;
    logic [7:0]  prefix_length;
    logic [7:0]  rule_kind;
    logic [7:0]  target_kind;
    logic [31:0] rules_decoded;
    modport source (output valid, output event_res, output interface_id, output ipv4_prefix,
                    output prefix_length, output rule_kind, output target_kind,
                    output rules_decoded, input ready);
    modport sink (input valid, input event_res, input interface_id, input ipv4_prefix,
                  input prefix_length, input rule_kind, input target_kind,
                  input rules_decoded, output ready);
endinterface

/* rtl/core/isre_parser.sv */
`timescale 1ns / 1ps
module isre_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic              i_start,
    input  isre_pkg::t_cfg    i_cfg,
    output logic              o_push,
    output isre_pkg::t_result o_result
);

    isre_pkg::t_phase r_phase, n_phase, c_phase;
    logic        r_halted, n_halted, c_halted;
    logic [15:0] r_mo, n_mo, c_mo;
    logic [15:0] r_ml, n_ml, c_ml;
    logic [15:0] r_so, n_so, c_so;
    logic [15:0] r_sl, n_sl, c_sl;
    logic [15:0] r_ll, n_ll, c_ll;
    logic [15:0] r_lo, n_lo, c_lo;
    logic [31:0] r_hs, n_hs, c_hs;
    logic [63:0] r_es, n_es, c_es;
    logic [7:0]  r_rk, n_rk, c_rk;
    logic [7:0]  r_tk, n_tk, c_tk;
    logic [31:0] r_cnt, n_cnt, c_cnt;
    logic [4:0]  r_ii, n_ii, c_ii;

    logic [31:0] hs_sh;
    logic [16:0] diff;
    logic [17:0] lhs;
    logic [17:0] rhs;
    logic        ent_short;

    always_comb begin
        c_phase  = i_start ? isre_pkg::PH_MHDR : r_phase;
        c_halted = i_start ? 1'b0 : r_halted;
        c_mo     = i_start ? 16'd0 : r_mo;
        c_ml     = i_start ? 16'd0 : r_ml;
        c_so     = i_start ? 16'd0 : r_so;
        c_sl     = i_start ? 16'd0 : r_sl;
        c_ll     = i_start ? 16'd0 : r_ll;
        c_lo     = i_start ? 16'd0 : r_lo;
        c_hs     = i_start ? 32'd0 : r_hs;
        c_es     = i_start ? 64'd0 : r_es;
        c_rk     = i_start ? 8'd0 : r_rk;
        c_tk     = i_start ? 8'd0 : r_tk;
        c_cnt    = i_start ? 32'd0 : r_cnt;
        c_ii     = i_start ? 5'd0 : r_ii;

        n_phase = c_phase; n_halted = c_halted; n_mo = c_mo; n_ml = c_ml;
        n_so = c_so; n_sl = c_sl; n_ll = c_ll; n_lo = c_lo; n_hs = c_hs;
        n_es = c_es; n_rk = c_rk; n_tk = c_tk; n_cnt = c_cnt; n_ii = c_ii;
        o_push = 1'b0;
        o_result = '0;
        hs_sh = {c_hs[23:0], i_byte};
        diff = '0;
        lhs = '0;
        rhs = '0;
        ent_short = 1'b0;

        if (!c_halted) begin
            n_mo = c_mo + 16'd1;
            if (c_phase >= isre_pkg::PH_SHDR) n_so = c_so + 16'd1;
            if (c_phase >= isre_pkg::PH_LHDR) n_lo = c_lo + 16'd1;
            if (c_phase == isre_pkg::PH_RHDR || c_phase >= isre_pkg::PH_E4) n_ii = c_ii + 5'd1;
            diff = {1'b0, c_ll} - {1'b0, n_lo};

            case (c_phase)
                isre_pkg::PH_MHDR: begin
                    n_hs = hs_sh;
                    if (c_mo == 16'd3) begin
                        if (hs_sh[15:0] < isre_pkg::MSG_HDR_LEN) begin
                            n_halted = 1'b1;
                            o_push = 1'b1;
                            o_result.event_res = isre_pkg::EV_BAD_MSG_LEN;
                        end else begin
                            n_ml = hs_sh[15:0];
                            if (hs_sh[31:16] != isre_pkg::PROTO_VERSION) begin
                                n_phase = isre_pkg::PH_MSKIP;
                                o_push = 1'b1;
                                o_result.event_res = isre_pkg::EV_BAD_VERSION;
                            end
                        end
                    end
                end
                isre_pkg::PH_SHDR: begin
                    n_hs = hs_sh;
                    if (c_so == 16'd3) begin
                        lhs = {2'b0, hs_sh[15:0]} + {2'b0, c_mo};
                        rhs = {2'b0, c_ml} + 18'd3;
                        if (hs_sh[15:0] < 16'd4 || lhs > rhs) begin
                            n_phase = isre_pkg::PH_MSKIP;
                            o_push = 1'b1;
                            o_result.event_res = isre_pkg::EV_BAD_SET_LEN;
                        end else begin
                            n_sl = hs_sh[15:0];
                            if (hs_sh[31:16] != isre_pkg::TEMPLATE_SET_ID
                                && hs_sh[31:16] == i_cfg.rule_set_id) begin
                                diff = {1'b0, hs_sh[15:0]} - {1'b0, n_so};
                                if (!diff[16] && diff[15:0] < 16'd4) begin
                                    n_phase = isre_pkg::PH_SSKIP;
                                end else begin
                                    n_phase = isre_pkg::PH_RHDR;
                                    n_ii = 5'd0;
                                    n_hs = '0;
                                end
                            end else begin
                                n_phase = isre_pkg::PH_SSKIP;
                            end
                        end
                    end
                end
                isre_pkg::PH_RHDR: begin
                    n_hs = hs_sh;
                    if (c_ii == 5'd3) begin
                        n_rk = hs_sh[31:24];
                        n_tk = hs_sh[23:16];
                        lhs = {2'b0, n_so} + {2'b0, hs_sh[15:0]} + 18'd1;
                        if (lhs > {2'b0, c_sl}) begin
                            n_phase = isre_pkg::PH_SSKIP;
                            o_push = 1'b1;
                            o_result.event_res = isre_pkg::EV_TRUNC_REC;
                            o_result.rule_kind = hs_sh[31:24];
                            o_result.target_kind = hs_sh[23:16];
                        end else begin
                            n_ll = hs_sh[15:0];
                            n_lo = 16'd0;
                            if (hs_sh[15:0] == 16'd0) begin
                                n_phase = isre_pkg::PH_POLICY;
                            end else if (hs_sh[15:0] < 16'd3) begin
                                n_phase = isre_pkg::PH_LSKIP;
                                o_push = 1'b1;
                                o_result.event_res = isre_pkg::EV_BAD_LIST;
                                o_result.rule_kind = hs_sh[31:24];
                                o_result.target_kind = hs_sh[23:16];
                            end else begin
                                n_phase = isre_pkg::PH_LHDR;
                                n_hs = '0;
                            end
                        end
                    end
                end
                isre_pkg::PH_POLICY: begin
                    diff = {1'b0, c_sl} - {1'b0, n_so};
                    if (!diff[16] && diff[15:0] < 16'd4) begin
                        n_phase = isre_pkg::PH_SSKIP;
                    end else begin
                        n_phase = isre_pkg::PH_RHDR;
                        n_ii = 5'd0;
                        n_hs = '0;
                    end
                end
                isre_pkg::PH_LHDR: begin
                    n_hs = hs_sh;
                    if (c_lo == 16'd2) begin
                        if (hs_sh[15:0] == i_cfg.ipv4_list_template) begin
                            ent_short = !diff[16] && {1'b0, diff[15:0]} < isre_pkg::E4_BYTES;
                            n_phase = ent_short ? isre_pkg::PH_LSKIP : isre_pkg::PH_E4;
                            if (!ent_short) begin n_ii = 5'd0; n_es = '0; end
                        end else if (hs_sh[15:0] == i_cfg.ipv6_list_template) begin
                            ent_short = !diff[16] && {1'b0, diff[15:0]} < isre_pkg::E6_BYTES;
                            n_phase = ent_short ? isre_pkg::PH_LSKIP : isre_pkg::PH_E6;
                            if (!ent_short) begin n_ii = 5'd0; n_es = '0; end
                        end else begin
                            n_phase = isre_pkg::PH_LSKIP;
                            o_push = 1'b1;
                            o_result.event_res = isre_pkg::EV_BAD_LIST;
                            o_result.rule_kind = c_rk;
                            o_result.target_kind = c_tk;
                        end
                    end
                end
                isre_pkg::PH_E4: begin
                    if (c_ii < isre_pkg::E4_LAST) begin
                        n_es = {c_es[55:0], i_byte};
                    end else begin
                        if (c_cnt != 32'hFFFF_FFFF) n_cnt = c_cnt + 32'd1;
                        o_push = 1'b1;
                        o_result.event_res = isre_pkg::EV_RULE;
                        o_result.interface_id = c_es[63:32];
                        o_result.ipv4_prefix = c_es[31:0];
                        o_result.prefix_length = i_byte;
                        o_result.rule_kind = c_rk;
                        o_result.target_kind = c_tk;
                        ent_short = !diff[16] && {1'b0, diff[15:0]} < isre_pkg::E4_BYTES;
                        n_phase = ent_short ? isre_pkg::PH_LSKIP : isre_pkg::PH_E4;
                        if (!ent_short) begin n_ii = 5'd0; n_es = '0; end
                    end
                end
                isre_pkg::PH_E6: begin
                    if (c_ii >= isre_pkg::E6_LAST) begin
                        ent_short = !diff[16] && {1'b0, diff[15:0]} < isre_pkg::E6_BYTES;
                        n_phase = ent_short ? isre_pkg::PH_LSKIP : isre_pkg::PH_E6;
                        if (!ent_short) begin n_ii = 5'd0; n_es = '0; end
                    end
                end
                default: begin
                end
            endcase

            o_result.rules_decoded = n_cnt;

            if (n_mo >= isre_pkg::MSG_HDR_LEN && n_mo == n_ml && !n_halted) begin
                n_phase = isre_pkg::PH_MHDR;
                n_mo = 16'd0;
                n_hs = '0;
            end else if ((n_phase == isre_pkg::PH_MHDR && n_mo == isre_pkg::MSG_HDR_LEN)
                         || (n_phase >= isre_pkg::PH_SSKIP && n_so == n_sl)) begin
                diff = {1'b0, n_ml} - {1'b0, n_mo};
                if (!diff[16] && diff[15:0] < 16'd4) begin
                    n_phase = isre_pkg::PH_MSKIP;
                end else begin
                    n_phase = isre_pkg::PH_SHDR;
                    n_so = 16'd0;
                    n_hs = '0;
                end
            end else if (n_phase >= isre_pkg::PH_LHDR && n_lo == n_ll) begin
                n_phase = isre_pkg::PH_POLICY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= isre_pkg::PH_MHDR;
            r_halted <= 1'b0;
            r_mo <= '0; r_ml <= '0; r_so <= '0; r_sl <= '0;
            r_ll <= '0; r_lo <= '0; r_hs <= '0; r_es <= '0;
            r_rk <= '0; r_tk <= '0; r_cnt <= '0; r_ii <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_halted <= n_halted;
            r_mo <= n_mo; r_ml <= n_ml; r_so <= n_so; r_sl <= n_sl;
            r_ll <= n_ll; r_lo <= n_lo; r_hs <= n_hs; r_es <= n_es;
            r_rk <= n_rk; r_tk <= n_tk; r_cnt <= n_cnt; r_ii <= n_ii;
        end
    end

endmodule

/* rtl/core/isre_fifo.sv */
`timescale 1ns / 1ps
module isre_fifo #(
    parameter int DEPTH = isre_pkg::FIFO_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  isre_pkg::t_result i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output isre_pkg::t_result o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    isre_pkg::t_result r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            if (i_pop) r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            if (i_push && !i_pop) r_cnt <= r_cnt + CW'(1);
            else if (!i_push && i_pop) r_cnt <= r_cnt - CW'(1);
        end
    end

endmodule

/* rtl/core/isre_out_stage.sv */
`timescale 1ns / 1ps
module isre_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  isre_pkg::t_result i_data,
    output logic              o_pop,
    isre_out_if.source        o_res
);

    logic r_valid;
    isre_pkg::t_result r_data;

    assign o_pop = !i_empty && (!r_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || o_res.ready) begin
            r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_data <= i_data;
    end

    assign o_res.valid         = r_valid;
    assign o_res.event_res     = r_data.event_res;
    assign o_res.interface_id  = r_data.interface_id;
    assign o_res.ipv4_prefix   = r_data.ipv4_prefix;
    assign o_res.prefix_length = r_data.prefix_length;
    assign o_res.rule_kind     = r_data.rule_kind;
    assign o_res.target_kind   = r_data.target_kind;
    assign o_res.rules_decoded = r_data.rules_decoded;

endmodule

/* rtl/core/ipfix_sav_rule_extractor_core.sv */
`timescale 1ns / 1ps
// parses an ipfix-over-tcp byte stream at one byte per clock and reports one
// result per extracted ipv4 rule or detected error; the byte parser accepts a
// byte every cycle while its result queue has room, and an output register
// delivers queued results, so a result passes the queue, then that register;
// only a stalled output side slows the input, once the queue fills
module ipfix_sav_rule_extractor_core #(
    parameter int FIFO_DEPTH = isre_pkg::FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    isre_in_if.sink     i_req,
    isre_out_if.source  o_res,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    isre_pkg::t_cfg    r_cfg;
    isre_pkg::t_result push_data, head_data;
    logic accept, push, pop, full, empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rule_set_id        <= isre_pkg::RST_RULE_SET_ID;
            r_cfg.ipv4_list_template <= isre_pkg::RST_IPV4_TMPL;
            r_cfg.ipv6_list_template <= isre_pkg::RST_IPV6_TMPL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                isre_pkg::CFG_RULE_SET_ID: r_cfg.rule_set_id <= i_cfg_data;
                isre_pkg::CFG_IPV4_TMPL:   r_cfg.ipv4_list_template <= i_cfg_data;
                isre_pkg::CFG_IPV6_TMPL:   r_cfg.ipv6_list_template <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign i_req.ready = !full;
    assign accept = i_req.valid && !full;

    isre_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_req.data_byte),
        .i_start  (i_req.stream_start),
        .i_cfg    (r_cfg),
        .o_push   (push),
        .o_result (push_data)
    );

    isre_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && accept),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_data  (head_data)
    );

    isre_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_data  (head_data),
        .o_pop   (pop),
        .o_res   (o_res)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && accept && full))
        else $error("result queue overflow");

    a_rule_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.event_res == isre_pkg::EV_RULE) |-> o_res.rules_decoded != 32'd0)
        else $error("rule reported with zero count");

    a_error_no_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.event_res != isre_pkg::EV_RULE)
        |-> (o_res.interface_id == 32'd0 && o_res.ipv4_prefix == 32'd0))
        else $error("error event carries entry data");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_res.valid)
        else $error("output valid right after reset");

endmodule
